[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the checker clock.
`define BEI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication on the checker clock.
`define BEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bei_pkg.sv]
// Types, codes and constants of the breakpoint envelope interpolator.
package bei_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam logic [31:0] MIN_TOTAL = 32'd655360;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_QUERY   = 3'd1;
  localparam logic [2:0] OP_RESCALE = 3'd2;
  localparam logic [2:0] OP_START   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        time_value;
    logic signed [31:0] level;
    logic [7:0]         point_number;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_level;
    logic [31:0]        segment_time;
    logic               out_of_range;
    logic               final_flag;
  } rsp_t;

  typedef struct packed {
    logic [31:0] a;
    logic [32:0] b;
    logic [31:0] d;
  } md_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DROP,
    S_LD_RD,
    S_LD_WR,
    S_Q_TL,
    S_Q_TLD,
    S_Q_DN_RD,
    S_Q_DN_CK,
    S_Q_UP_RD,
    S_Q_UP_CK,
    S_Q_FIN,
    S_Q_OOR,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_MD,
    S_Q_WAIT,
    S_R_DEN,
    S_R_DCK,
    S_R_RD,
    S_R_MD,
    S_R_WAIT,
    S_ST_RD0,
    S_ST_0,
    S_ST_RD1,
    S_ST_1,
    S_TK_RD1,
    S_TK_RD2,
    S_TK_OUT,
    S_EMIT
  } state_t;

  function automatic logic [31:0] time_rst(input logic [1:0] i);
    case (i)
      2'd1:    time_rst = 32'd50 << 16;
      2'd2:    time_rst = 32'd100 << 16;
      default: time_rst = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] level_rst(input logic [1:0] i);
    case (i)
      2'd1:    level_rst = 32'd65536;
      default: level_rst = 32'd0;
    endcase
  endfunction

endpackage

[rtl/bei_ram.sv]
// Generic single-port-write, registered-read RAM.
module bei_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bei_muldiv.sv]
// Bit-serial multiply then restoring divide: q = (a * b) / d.
module bei_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bei_pkg::md_req_t md_in,
  output logic             done,
  output logic [64:0]      q
);

  bei_pkg::md_phase_t phase, phase_next;
  logic [6:0]  cnt;
  logic [65:0] p;
  logic [31:0] rem;
  logic [31:0] areg;
  logic [31:0] dreg;
  logic [33:0] sum;
  logic [32:0] r2;
  logic        ge;

  assign sum = {1'b0, p[65:33]} + (p[0] ? {2'b0, areg} : 34'd0);
  assign r2  = {rem, p[64]};
  assign ge  = r2 >= {1'b0, dreg};
  assign q   = p[64:0];

  always_comb begin
    phase_next = phase;
    case (phase)
      bei_pkg::MD_IDLE: if (start) phase_next = bei_pkg::MD_MUL;
      bei_pkg::MD_MUL:  if (cnt == 7'd32) phase_next = bei_pkg::MD_DIV;
      bei_pkg::MD_DIV:  if (cnt == 7'd64) phase_next = bei_pkg::MD_IDLE;
      default:          phase_next = bei_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bei_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == bei_pkg::MD_DIV) && (cnt == 7'd64);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      bei_pkg::MD_IDLE: begin
        if (start) begin
          areg <= md_in.a;
          dreg <= md_in.d;
          p    <= {33'd0, md_in.b};
          cnt  <= 7'd0;
        end
      end
      bei_pkg::MD_MUL: begin
        p   <= {sum, p[32:1]};
        cnt <= (cnt == 7'd32) ? 7'd0 : cnt + 7'd1;
        rem <= 32'd0;
      end
      bei_pkg::MD_DIV: begin
        rem     <= ge ? 32'(r2 - {1'b0, dreg}) : r2[31:0];
        p[64:0] <= {p[63:0], ge};
        cnt     <= cnt + 7'd1;
      end
      default: begin
        cnt <= 7'd0;
      end
    endcase
  end

endmodule

[rtl/breakpoint_envelope_interpolator.sv]
// Top level: breakpoint table, cursor walk, interpolation, rescale and playback.
// Query walks the cursor and, when it interpolates, uses the serial multiply
// and divide; rescale runs each point after the first through the shared
// multiply-divide unit. A tick that falls outside the table gives nothing.
// One request at a time; reset is synchronous, with no clearing pass.
module breakpoint_envelope_interpolator #(
  parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bei_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bei_pkg::rsp_t rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int PW = $clog2(MAX_POINTS + 1);

  bei_pkg::state_t state, state_next;

  logic [31:0]        tv;
  logic signed [31:0] lv;
  logic [AW-1:0]      pn;
  logic [AW-1:0]      last;
  logic [AW-1:0]      cursor;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      idx;
  logic [PW-1:0]      pp;
  logic [PW-1:0]      pp_inc;
  logic [31:0]        t0, t1, tlast;
  logic signed [31:0] l0, l1;
  logic               neg;
  logic               ret_start;
  bei_pkg::rsp_t      res;
  logic [2:0]         tvld, lvld;
  logic [AW-1:0]      t_ra_q, l_ra_q;

  logic          accept, slot_free, emit, tick_hit, load_bad;
  logic          t_we, l_we;
  logic [AW-1:0] t_waddr, l_waddr, t_raddr, l_raddr;
  logic [31:0]   t_wdata, l_wdata, t_mem, l_mem, t_rd;
  logic signed [31:0] l_rd;
  logic [32:0]   ld_sum;
  logic          md_start, md_done;
  bei_pkg::md_req_t md_in;
  logic [64:0]   md_q;
  logic signed [32:0] dl;
  logic [33:0]   qs;
  logic signed [35:0] isum;
  logic signed [31:0] ires;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != bei_pkg::S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign pp_inc    = (pp < PW'(MAX_POINTS)) ? pp + PW'(1) : pp;
  assign tick_hit  = (pp_inc <= PW'(last)) && (pp_inc >= PW'(1)) &&
                     (pp_inc < PW'(MAX_POINTS));
  assign load_bad  = {24'd0, req.point_number} >= 32'(MAX_POINTS);

  assign t_rd = ((t_ra_q < AW'(3)) && !tvld[t_ra_q[1:0]]) ?
                bei_pkg::time_rst(t_ra_q[1:0]) : t_mem;
  assign l_rd = ((l_ra_q < AW'(3)) && !lvld[l_ra_q[1:0]]) ?
                bei_pkg::level_rst(l_ra_q[1:0]) : l_mem;

  assign ld_sum = {1'b0, t_rd} + {1'b0, tv};
  assign dl     = 33'(l1) - 33'(l0);
  assign qs     = (md_q > 65'h200000000) ? 34'h200000000 : md_q[33:0];
  assign isum   = neg ? 36'(l0) - {2'b0, qs} : 36'(l0) + {2'b0, qs};
  assign ires   = (isum > 36'sd2147483647) ? 32'sh7FFFFFFF :
                  (isum < -36'sd2147483648) ? 32'sh80000000 : isum[31:0];

  bei_ram #(.W(32), .DEPTH(MAX_POINTS)) u_times (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_mem)
  );

  bei_ram #(.W(32), .DEPTH(MAX_POINTS)) u_levels (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_mem)
  );

  bei_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .md_in(md_in),
    .done(md_done), .q(md_q)
  );

  always_comb begin
    state_next = state;
    t_raddr    = '0;
    l_raddr    = '0;
    t_we       = 1'b0;
    t_waddr    = pn;
    t_wdata    = '0;
    l_we       = 1'b0;
    l_waddr    = pn;
    l_wdata    = lv;
    md_start   = 1'b0;
    md_in      = '0;
    emit       = 1'b0;
    case (state)
      bei_pkg::S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            bei_pkg::OP_LOAD:
              state_next = load_bad ? bei_pkg::S_DROP : bei_pkg::S_LD_RD;
            bei_pkg::OP_QUERY:   state_next = bei_pkg::S_Q_TL;
            bei_pkg::OP_RESCALE:
              state_next = (req.time_value < bei_pkg::MIN_TOTAL) ?
                           bei_pkg::S_DROP : bei_pkg::S_R_DEN;
            bei_pkg::OP_START:   state_next = bei_pkg::S_ST_RD0;
            bei_pkg::OP_TICK:
              state_next = tick_hit ? bei_pkg::S_TK_RD1 : bei_pkg::S_DROP;
            default:             state_next = bei_pkg::S_DROP;
          endcase
        end
      end
      bei_pkg::S_DROP: state_next = bei_pkg::S_IDLE;
      bei_pkg::S_LD_RD: begin
        t_raddr    = pn - AW'(1);
        state_next = bei_pkg::S_LD_WR;
      end
      bei_pkg::S_LD_WR: begin
        t_we       = 1'b1;
        t_wdata    = (pn == '0) ? 32'd0 : (ld_sum[32] ? 32'hFFFFFFFF : ld_sum[31:0]);
        l_we       = 1'b1;
        state_next = bei_pkg::S_IDLE;
      end
      bei_pkg::S_Q_TL: begin
        t_raddr    = last;
        state_next = bei_pkg::S_Q_TLD;
      end
      bei_pkg::S_Q_TLD: state_next = bei_pkg::S_Q_DN_RD;
      bei_pkg::S_Q_DN_RD: begin
        if (cur == '0) begin
          state_next = bei_pkg::S_Q_UP_RD;
        end else begin
          t_raddr    = cur - AW'(1);
          state_next = bei_pkg::S_Q_DN_CK;
        end
      end
      bei_pkg::S_Q_DN_CK:
        state_next = (tv < t_rd) ? bei_pkg::S_Q_DN_RD : bei_pkg::S_Q_UP_RD;
      bei_pkg::S_Q_UP_RD: begin
        if (cur == last) begin
          state_next = bei_pkg::S_Q_FIN;
        end else begin
          t_raddr    = cur;
          state_next = bei_pkg::S_Q_UP_CK;
        end
      end
      bei_pkg::S_Q_UP_CK:
        state_next = (t_rd < tv) ? bei_pkg::S_Q_UP_RD : bei_pkg::S_Q_FIN;
      bei_pkg::S_Q_FIN: begin
        if (cur == '0 || tv >= tlast) begin
          l_raddr    = cur;
          state_next = bei_pkg::S_Q_OOR;
        end else begin
          t_raddr    = cur - AW'(1);
          l_raddr    = cur - AW'(1);
          state_next = bei_pkg::S_Q_RD1;
        end
      end
      bei_pkg::S_Q_OOR: state_next = bei_pkg::S_EMIT;
      bei_pkg::S_Q_RD1: begin
        t_raddr    = cur;
        l_raddr    = cur;
        state_next = bei_pkg::S_Q_RD2;
      end
      bei_pkg::S_Q_RD2: state_next = bei_pkg::S_Q_MD;
      bei_pkg::S_Q_MD: begin
        if (t1 == t0) begin
          state_next = bei_pkg::S_EMIT;
        end else begin
          md_start   = 1'b1;
          md_in.a    = (tv >= t0) ? tv - t0 : t0 - tv;
          md_in.b    = dl[32] ? 33'(-dl) : 33'(dl);
          md_in.d    = (t1 > t0) ? t1 - t0 : t0 - t1;
          state_next = bei_pkg::S_Q_WAIT;
        end
      end
      bei_pkg::S_Q_WAIT: if (md_done) state_next = bei_pkg::S_EMIT;
      bei_pkg::S_R_DEN: begin
        t_raddr    = last;
        state_next = bei_pkg::S_R_DCK;
      end
      bei_pkg::S_R_DCK:
        state_next = (t_rd == 32'd0 || last == '0) ? bei_pkg::S_IDLE : bei_pkg::S_R_RD;
      bei_pkg::S_R_RD: begin
        t_raddr    = idx;
        state_next = bei_pkg::S_R_MD;
      end
      bei_pkg::S_R_MD: begin
        md_start   = 1'b1;
        md_in.a    = t_rd;
        md_in.b    = {1'b0, tv};
        md_in.d    = t0;
        state_next = bei_pkg::S_R_WAIT;
      end
      bei_pkg::S_R_WAIT: begin
        if (md_done) begin
          t_we       = 1'b1;
          t_waddr    = idx;
          t_wdata    = (md_q[64:32] != '0) ? 32'hFFFFFFFF : md_q[31:0];
          state_next = (idx == last) ? bei_pkg::S_IDLE : bei_pkg::S_R_RD;
        end
      end
      bei_pkg::S_ST_RD0: begin
        l_raddr    = AW'(0);
        state_next = bei_pkg::S_ST_0;
      end
      bei_pkg::S_ST_0: state_next = bei_pkg::S_EMIT;
      bei_pkg::S_ST_RD1: begin
        l_raddr    = AW'(1);
        t_raddr    = AW'(1);
        state_next = bei_pkg::S_ST_1;
      end
      bei_pkg::S_ST_1: state_next = bei_pkg::S_EMIT;
      bei_pkg::S_TK_RD1: begin
        t_raddr    = pp[AW-1:0] - AW'(1);
        state_next = bei_pkg::S_TK_RD2;
      end
      bei_pkg::S_TK_RD2: begin
        t_raddr    = pp[AW-1:0];
        l_raddr    = pp[AW-1:0];
        state_next = bei_pkg::S_TK_OUT;
      end
      bei_pkg::S_TK_OUT: state_next = bei_pkg::S_EMIT;
      bei_pkg::S_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = ret_start ? bei_pkg::S_ST_RD1 : bei_pkg::S_IDLE;
        end
      end
      default: state_next = bei_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bei_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      last      <= AW'(2);
      cursor    <= '0;
      pp        <= '0;
      tvld      <= '0;
      lvld      <= '0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (t_we && t_waddr < AW'(3)) tvld[t_waddr[1:0]] <= 1'b1;
      if (l_we && l_waddr < AW'(3)) lvld[l_waddr[1:0]] <= 1'b1;
      if (state == bei_pkg::S_LD_WR) last <= pn;
      if (state == bei_pkg::S_Q_FIN) cursor <= cur;
      if (accept && req.opcode == bei_pkg::OP_START) pp <= PW'(1);
      if (accept && req.opcode == bei_pkg::OP_TICK) pp <= pp_inc;
    end
  end

  always_ff @(posedge clk) begin
    t_ra_q <= t_raddr;
    l_ra_q <= l_raddr;
    if (emit) rsp <= res;
    case (state)
      bei_pkg::S_IDLE: begin
        tv        <= req.time_value;
        lv        <= req.level;
        pn        <= AW'(req.point_number);
        cur       <= (cursor > last) ? last : cursor;
        ret_start <= 1'b0;
      end
      bei_pkg::S_Q_TLD: tlast <= t_rd;
      bei_pkg::S_Q_DN_CK: if (tv < t_rd) cur <= cur - AW'(1);
      bei_pkg::S_Q_UP_CK: if (t_rd < tv) cur <= cur + AW'(1);
      bei_pkg::S_Q_OOR: res <= '{out_level: l_rd, segment_time: 32'd0,
                                 out_of_range: 1'b1, final_flag: 1'b1};
      bei_pkg::S_Q_RD1: begin
        t0 <= t_rd;
        l0 <= l_rd;
      end
      bei_pkg::S_Q_RD2: begin
        t1 <= t_rd;
        l1 <= l_rd;
      end
      bei_pkg::S_Q_MD: begin
        neg <= (tv < t0) ^ dl[32] ^ (t1 < t0);
        res <= '{out_level: l0, segment_time: 32'd0,
                 out_of_range: 1'b0, final_flag: 1'b1};
      end
      bei_pkg::S_Q_WAIT: if (md_done) res.out_level <= ires;
      bei_pkg::S_R_DCK: begin
        t0  <= t_rd;
        idx <= AW'(1);
      end
      bei_pkg::S_R_WAIT: if (md_done) idx <= idx + AW'(1);
      bei_pkg::S_ST_0: begin
        res <= '{out_level: l_rd, segment_time: 32'd0,
                 out_of_range: 1'b0, final_flag: 1'b0};
        ret_start <= 1'b1;
      end
      bei_pkg::S_ST_1: begin
        res <= '{out_level: l_rd, segment_time: t_rd,
                 out_of_range: 1'b0, final_flag: 1'b1};
        ret_start <= 1'b0;
      end
      bei_pkg::S_TK_RD2: t0 <= t_rd;
      bei_pkg::S_TK_OUT:
        res <= '{out_level: l_rd, segment_time: (t_rd > t0) ? t_rd - t0 : 32'd0,
                 out_of_range: 1'b0, final_flag: 1'b1};
      default: ;
    endcase
  end

endmodule

[rtl/bei_checker.sv]
// Port-level checker for the breakpoint envelope interpolator, bound to the top level.
`include "assert_macros.svh"

module bei_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input bei_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bei_pkg::rsp_t rsp
);

  `BEI_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
  `BEI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `BEI_ASSERT_NOW(a_oor_final, rsp_valid && rsp.out_of_range, rsp.final_flag)
  `BEI_ASSERT_NOW(a_oor_no_time, rsp_valid && rsp.out_of_range, rsp.segment_time == 32'd0)

endmodule

bind breakpoint_envelope_interpolator bei_checker u_bei_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

[sim/breakpoint_envelope_interpolator_test.sv]
// Self-checking testbench for the breakpoint envelope interpolator.
module breakpoint_envelope_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = bei_pkg::MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [31:0] MS = 32'd65536;

  typedef struct {
    bei_pkg::req_t r;
    bit            typed;
    bei_pkg::rsp_t e;
  } step_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  bei_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  bei_pkg::rsp_t rsp;

  breakpoint_envelope_interpolator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  logic [31:0]        pt_time [DEPTH];
  logic signed [31:0] pt_level [DEPTH];
  int unsigned        last_pt;
  int unsigned        cursor;
  int unsigned        play_pos;
  int                 depth_goal = 4;
  bei_pkg::rsp_t      envelope_q[$];
  int                 errors = 0;
  int unsigned        cyc = 0;
  bit                 quiet;

  assign quiet = (cyc >= 40000) && (cyc < 60000);

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bei_pkg::rsp_t mk(logic signed [31:0] l, logic [31:0] st, logic o,
      logic f);
    bei_pkg::rsp_t x;
    x.out_level = l;
    x.segment_time = st;
    x.out_of_range = o;
    x.final_flag = f;
    return x;
  endfunction

  function automatic logic signed [31:0] interpolate(logic [31:0] t, logic [31:0] t0,
      logic [31:0] t1, logic signed [31:0] l0, logic signed [31:0] l1);
    logic [127:0]       a;
    logic [127:0]       b;
    logic [127:0]       d;
    logic [127:0]       q;
    logic signed [33:0] dl;
    logic signed [65:0] r;
    bit                 neg;
    if (t1 == t0) return l0;
    neg = 0;
    if (t >= t0) a = t - t0;
    else begin
      a = t0 - t;
      neg = !neg;
    end
    dl = l1 - l0;
    if (dl >= 0) b = dl;
    else begin
      b = -dl;
      neg = !neg;
    end
    if (t1 > t0) d = t1 - t0;
    else begin
      d = t0 - t1;
      neg = !neg;
    end
    q = (a * b) / d;
    if (q > 128'h2_0000_0000) q = 128'h2_0000_0000;
    r = neg ? l0 - $signed({1'b0, q[33:0]}) : l0 + $signed({1'b0, q[33:0]});
    if (r > 66'sd2147483647) r = 66'sd2147483647;
    if (r < -66'sd2147483648) r = -66'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict(bei_pkg::req_t r);
    int unsigned p;
    int unsigned c;
    logic [32:0] s;
    logic [63:0] q;
    logic [31:0] den;
    case (r.opcode)
      bei_pkg::OP_LOAD: begin
        if (r.point_number < DEPTH) begin
          p = r.point_number;
          if (p == 0) pt_time[0] = '0;
          else begin
            s = {1'b0, pt_time[p-1]} + r.time_value;
            pt_time[p] = s[32] ? '1 : s[31:0];
          end
          pt_level[p] = r.level;
          last_pt = p;
        end
      end
      bei_pkg::OP_QUERY: begin
        c = (cursor > last_pt) ? last_pt : cursor;
        while (c > 0 && r.time_value < pt_time[c-1]) c--;
        while (c < last_pt && pt_time[c] < r.time_value) c++;
        cursor = c;
        if (c == 0 || r.time_value >= pt_time[last_pt])
          envelope_q.push_back(mk(pt_level[c], '0, 1'b1, 1'b1));
        else
          envelope_q.push_back(mk(interpolate(r.time_value, pt_time[c-1], pt_time[c],
              pt_level[c-1], pt_level[c]), '0, 1'b0, 1'b1));
      end
      bei_pkg::OP_RESCALE: begin
        den = pt_time[last_pt];
        if (r.time_value >= bei_pkg::MIN_TOTAL && den != 0) begin
          for (int i = 1; i <= last_pt; i++) begin
            q = ({32'b0, pt_time[i]} * {32'b0, r.time_value}) / {32'b0, den};
            pt_time[i] = (|q[63:32]) ? '1 : q[31:0];
          end
        end
      end
      bei_pkg::OP_START: begin
        envelope_q.push_back(mk(pt_level[0], '0, 1'b0, 1'b0));
        play_pos = 1;
        envelope_q.push_back(mk(pt_level[1], pt_time[1], 1'b0, 1'b1));
      end
      bei_pkg::OP_TICK: begin
        if (play_pos < DEPTH) play_pos++;
        p = play_pos;
        if (p <= last_pt && p >= 1 && p < DEPTH)
          envelope_q.push_back(mk(pt_level[p],
              (pt_time[p] > pt_time[p-1]) ? pt_time[p] - pt_time[p-1] : '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic bei_pkg::req_t noise_req();
    bei_pkg::req_t r;
    r.opcode = 3'($urandom_range(7));
    r.time_value = $urandom;
    r.level = $urandom;
    r.point_number = 8'($urandom_range(255));
    return r;
  endfunction

  // Build mostly well-formed table/query/playback traffic; returns 1 when it counts.
  function automatic bit next_request(output bei_pkg::req_t r);
    int unsigned sel;
    int unsigned k;
    logic [31:0] base;
    r = noise_req();
    sel = $urandom_range(99);
    k = $urandom_range(9);
    if (sel < 30) begin
      r.opcode = bei_pkg::OP_LOAD;
      if (last_pt >= depth_goal || $urandom_range(15) == 0) begin
        r.point_number = 0;
        depth_goal = ($urandom_range(14) == 0) ? DEPTH - 1 : $urandom_range(1, 10);
      end else r.point_number = 8'(last_pt + 1);
      if (k == 0) r.time_value = '0;
      else if (k != 1) r.time_value = $urandom_range(1, 100 * MS);
      if ($urandom_range(3) == 0) r.level = $signed($urandom_range(0, 20 * MS)) - 10 * MS;
    end else if (sel < 65) begin
      r.opcode = bei_pkg::OP_QUERY;
      base = pt_time[$urandom_range(last_pt)];
      if (k == 1 || k == 2) r.time_value = base;
      else if (k == 3) r.time_value = base - $urandom_range(0, 1 << 20);
      else if (k != 0) r.time_value = base + $urandom_range(0, 1 << 20);
    end else if (sel < 70) begin
      r.opcode = bei_pkg::OP_START;
    end else if (sel < 85) begin
      r.opcode = bei_pkg::OP_TICK;
    end else if (sel < 90) begin
      r.opcode = (last_pt > 20 && $urandom_range(7) != 0) ? bei_pkg::OP_TICK :
                 bei_pkg::OP_RESCALE;
      if (k == 0) r.time_value = $urandom_range(0, bei_pkg::MIN_TOTAL - 1);
      else if (k < 7) r.time_value = $urandom_range(bei_pkg::MIN_TOTAL, 2000 * MS);
    end else if (sel < 95) begin
      r.opcode = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      return 0;
    end else begin
      r.opcode = bei_pkg::OP_LOAD;
      r.point_number = 8'($urandom_range(DEPTH, 255));
      return 0;
    end
    return 1;
  endfunction

  task automatic offer(bei_pkg::req_t r, bit typed, bei_pkg::rsp_t e);
    if (!quiet && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict(r);
    if (typed) envelope_q[$] = e;
  endtask

  task automatic note(string what, bei_pkg::rsp_t e, bei_pkg::rsp_t a);
    errors++;
    if (errors <= 10)
      $display("%s: expected %0d/%h/%b/%b got %0d/%h/%b/%b", what,
          e.out_level, e.segment_time, e.out_of_range, e.final_flag,
          a.out_level, a.segment_time, a.out_of_range, a.final_flag);
  endtask

  step_t steps[] = '{
    '{'{bei_pkg::OP_QUERY, 32'd0, 32'sd0, 8'd0}, 1, '{32'sd0, 32'd0, 1'b1, 1'b1}},
    '{'{bei_pkg::OP_QUERY, 100 * MS, 32'sd0, 8'd0}, 1, '{32'sd0, 32'd0, 1'b1, 1'b1}},
    '{'{bei_pkg::OP_QUERY, 25 * MS, 32'sd0, 8'd0}, 1, '{32'sd32768, 32'd0, 1'b0, 1'b1}},
    '{'{bei_pkg::OP_START, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_TICK, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_TICK, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{OP_RSVD_LO, 32'hFFFFFFFF, 32'sh7FFFFFFF, 8'hFF}, 0, '0},
    '{'{OP_RSVD_HI, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd0, 32'sh80000000, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'hFFFFFFFF, 32'sh7FFFFFFF, 8'd1}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd1, 32'sd0, 8'd2}, 0, '0},
    '{'{bei_pkg::OP_QUERY, 32'hFFFFFFFE, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_QUERY, 32'hFFFFFFFF, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_RESCALE, bei_pkg::MIN_TOTAL - 1, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_RESCALE, bei_pkg::MIN_TOTAL, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd5, 32'sd1, 8'd200}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd5, 32'sd1, 8'd128}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd0, 5 * MS, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_QUERY, 3 * MS, 32'sd0, 8'd0}, 1, '{5 * MS, 32'd0, 1'b1, 1'b1}},
    '{'{bei_pkg::OP_RESCALE, 20 * MS, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_TICK, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_START, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd0, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 10 * MS, 3 * MS, 8'd1}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 32'd0, 9 * MS, 8'd2}, 0, '0},
    '{'{bei_pkg::OP_QUERY, 10 * MS, 32'sd0, 8'd0}, 0, '0},
    '{'{bei_pkg::OP_LOAD, 10 * MS, 1 * MS, 8'd3}, 0, '0},
    '{'{bei_pkg::OP_QUERY, 10 * MS, 32'sd0, 8'd0}, 0, '0}
  };

  initial begin
    bei_pkg::req_t r;
    for (int i = 0; i < DEPTH; i++) begin
      pt_time[i] = '0;
      pt_level[i] = '0;
    end
    pt_level[1] = 32'sd65536;
    pt_time[1] = 50 * MS;
    pt_time[2] = 100 * MS;
    last_pt = 2;
    cursor = 0;
    play_pos = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (steps[i]) offer(steps[i].r, steps[i].typed, steps[i].e);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      void'(next_request(r));
      offer(r, 0, '0);
    end
    req_valid <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk);
    repeat (14000) @(posedge clk);
    if (errors == 0 && envelope_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (envelope_q.size() == 0) note("unexpected result", '0, rsp);
        else if (rsp !== envelope_q[0]) note("mismatch", envelope_q.pop_front(), rsp);
        else void'(envelope_q.pop_front());
      end
      if (hold > 0) begin
        hold--;
        rsp_stall <= 1'b1;
      end else if (!held && cyc >= 5000) begin
        held = 1;
        hold = 600;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

endmodule
